// ===== hdl/cfde_pkg.sv =====
// cfde_pkg: command codes, stream and field widths and the 5x7 font rom
// used by the clipped framebuffer draw engine. no dependencies.

package cfde_pkg;

  // command codes
  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_BLIT = 2'd1;
  localparam logic [1:0] OP_CHAR = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;

  localparam int COUNT_W = 15;
  localparam int COLOR_W = 16;

  // glyph geometry and character mapping
  localparam logic [7:0] GLYPH_FIRST   = 8'd32;
  localparam logic [7:0] GLYPH_LAST    = 8'd126;
  localparam logic [7:0] GLYPH_SUBST   = 8'd63;  // '?'
  localparam int         GLYPH_DEFINED = 59;
  localparam int         GLYPH_COLS    = 5;
  localparam int         GLYPH_ROWS    = 7;
  localparam logic [2:0] GLYPH_LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] GLYPH_LAST_ROW = 3'(GLYPH_ROWS - 1);

  typedef logic [GLYPH_ROWS-1:0] glyph_col_t;

  // one entry per glyph, column 0 in the top byte, bit 0 is the top row
  localparam logic [39:0] GLYPH_ROM [GLYPH_DEFINED] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  // lit rows of one glyph column; undefined glyphs and columns are blank
  function automatic glyph_col_t glyph_col(input logic [5:0] idx, input logic [2:0] col);
    logic [39:0] entry;
    int          sh;
    glyph_col_t  bits;
    bits = '0;
    if ((int'(idx) < GLYPH_DEFINED) && (int'(col) < GLYPH_COLS)) begin
      entry = GLYPH_ROM[idx];
      sh    = 8 * (GLYPH_COLS - 1 - int'(col));
      bits  = entry[sh +: GLYPH_ROWS];
    end
    return bits;
  endfunction

endpackage

// ===== hdl/clipped_framebuffer_draw_engine.sv =====
// Clipped framebuffer draw engine top level: RGB565 frame store, command sequencer
// and result register. depends on cfde_pkg.

// Draw engine over an SCREEN_WIDTH x SCREEN_HEIGHT RGB565 frame store kept in one
// single-port synchronous memory (one access per cycle, read data registered).
// After reset the store is swept to zero, one pixel per cycle, and no item is
// accepted during the sweep. Items are then handled one at a time and each gives
// one result item. The single memory port walks pixels: fill rectangle writes the
// clipped area, blit pixel writes at most one pixel, draw char makes 35 font pixel
// tests (none when the glyph is undefined), read pixel reads one pixel. in_tready
// rises at the same edge that loads the result into the output register. A new item
// is taken while the previous result still waits on the output; a finished item
// waits for it to drain.

module clipped_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pos_x[8:0] pos_y[17:9] size_w[25:18] size_h[33:26] color[49:34] char_code[57:50]
  input  logic [cfde_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op[1:0] first[2]
  input  logic [cfde_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_color[15:0] pixels_written[30:16]
  output logic [cfde_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [9:0]  SW10 = 10'(SCREEN_WIDTH);
  localparam logic signed [9:0]  SH10 = 10'(SCREEN_HEIGHT);
  localparam logic signed [10:0] SW11 = 11'(SCREEN_WIDTH);
  localparam logic signed [10:0] SH11 = 11'(SCREEN_HEIGHT);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_GLYPH  = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam int CW = cfde_pkg::COUNT_W;
  localparam int PW = cfde_pkg::COLOR_W;

  // frame store
  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [PW-1:0] mem_wdata;
  logic [7:0]    px, py;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;

  // captured command
  logic [1:0]        op_r, op_nxt;
  logic signed [8:0] x_r, x_nxt, y_r, y_nxt;
  logic [7:0]        w_r, w_nxt, h_r, h_nxt;
  logic [PW-1:0]     color_r, color_nxt;
  logic [7:0]        code_r, code_nxt;
  logic              first_r, first_nxt;

  // walk state
  logic [7:0]        cx_r, cx_nxt, cy_r, cy_nxt;
  logic [7:0]        x0_r, x0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic [5:0]        gidx_r, gidx_nxt;
  logic [2:0]        gq_r, gq_nxt, gr_r, gr_nxt;
  logic              rd_on_r, rd_on_nxt;
  logic [7:0]        brow_r, brow_nxt, bcol_r, bcol_nxt;

  // result
  logic [CW-1:0]     cnt_r, cnt_nxt, cnt_inc;
  logic [PW-1:0]     rc_r, rc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PW-1:0]     out_color_r, out_color_nxt;
  logic [CW-1:0]     out_cnt_r, out_cnt_nxt;

  // decode helpers
  logic signed [9:0]  xs10, ys10, bx, by, gx, gy;
  logic signed [10:0] xe, ye, x0s, y0s, x1s, y1s;
  logic [7:0]         br0, bc0, mcode, gofs;
  logic               bstale;
  cfde_pkg::glyph_col_t gbits;

  function automatic logic on_scr(input logic signed [9:0] sx, input logic signed [9:0] sy);
    return (sx >= 10'sd0) && (sx < SW10) && (sy >= 10'sd0) && (sy < SH10);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_color_r};

  assign cnt_inc = (cnt_r == {CW{1'b1}}) ? cnt_r : cnt_r + CW'(1);

  always_comb begin
    // clipping for fill
    xs10 = {x_r[8], x_r};
    ys10 = {y_r[8], y_r};
    xe   = {{2{x_r[8]}}, x_r} + $signed({3'b000, w_r});
    ye   = {{2{y_r[8]}}, y_r} + $signed({3'b000, h_r});
    x0s  = x_r[8] ? 11'sd0 : {{2{x_r[8]}}, x_r};
    y0s  = y_r[8] ? 11'sd0 : {{2{y_r[8]}}, y_r};
    x1s  = (xe > SW11) ? SW11 : xe;
    y1s  = (ye > SH11) ? SH11 : ye;
    // blit cursor after restart and stale check
    br0    = first_r ? 8'd0 : brow_r;
    bc0    = first_r ? 8'd0 : bcol_r;
    bstale = (bc0 >= w_r) || (br0 >= h_r);
    if (bstale) begin
      br0 = 8'd0;
      bc0 = 8'd0;
    end
    bx = xs10 + $signed({2'b00, bc0});
    by = ys10 + $signed({2'b00, br0});
    // glyph
    mcode = ((code_r < cfde_pkg::GLYPH_FIRST) || (code_r > cfde_pkg::GLYPH_LAST)) ?
            cfde_pkg::GLYPH_SUBST : code_r;
    gofs  = mcode - cfde_pkg::GLYPH_FIRST;
    gbits = cfde_pkg::glyph_col(gidx_r, gq_r);
    gx    = xs10 + $signed({7'd0, gq_r});
    gy    = ys10 + $signed({7'd0, gr_r});
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    color_nxt     = color_r;
    code_nxt      = code_r;
    first_nxt     = first_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    gidx_nxt      = gidx_r;
    gq_nxt        = gq_r;
    gr_nxt        = gr_r;
    rd_on_nxt     = rd_on_r;
    brow_nxt      = brow_r;
    bcol_nxt      = bcol_r;
    cnt_nxt       = cnt_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_color_nxt = out_color_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_wdata     = color_r;
    px            = 8'd0;
    py            = 8'd0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser[1:0];
          first_nxt = in_tuser[2];
          x_nxt     = $signed(in_tdata[8:0]);
          y_nxt     = $signed(in_tdata[17:9]);
          w_nxt     = in_tdata[25:18];
          h_nxt     = in_tdata[33:26];
          color_nxt = in_tdata[49:34];
          code_nxt  = in_tdata[57:50];
          cnt_nxt   = '0;
          rc_nxt    = '0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_r)
          cfde_pkg::OP_FILL: begin
            cx_nxt = x0s[7:0];
            cy_nxt = y0s[7:0];
            x0_nxt = x0s[7:0];
            x1_nxt = x1s[7:0];
            y1_nxt = y1s[7:0];
            state_nxt = ((x1s <= x0s) || (y1s <= y0s)) ? S_DONE : S_FILL;
          end
          cfde_pkg::OP_BLIT: begin
            state_nxt = S_DONE;
            if ((w_r == 8'd0) || (h_r == 8'd0)) begin
              brow_nxt = 8'd0;
              bcol_nxt = 8'd0;
            end else begin
              px = bx[7:0];
              py = by[7:0];
              if (on_scr(bx, by)) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_inc;
              end
              if ({1'b0, bc0} + 9'd1 >= {1'b0, w_r}) begin
                bcol_nxt = 8'd0;
                brow_nxt = ({1'b0, br0} + 9'd1 >= {1'b0, h_r}) ? 8'd0 : br0 + 8'd1;
              end else begin
                bcol_nxt = bc0 + 8'd1;
                brow_nxt = br0;
              end
            end
          end
          cfde_pkg::OP_CHAR: begin
            gidx_nxt  = gofs[5:0];
            gq_nxt    = 3'd0;
            gr_nxt    = 3'd0;
            state_nxt = (int'(gofs) >= cfde_pkg::GLYPH_DEFINED) ? S_DONE : S_GLYPH;
          end
          cfde_pkg::OP_READ: begin
            px        = x_r[7:0];
            py        = y_r[7:0];
            rd_on_nxt = on_scr(xs10, ys10);
            state_nxt = S_RDWAIT;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FILL: begin
        px      = cx_r;
        py      = cy_r;
        mem_we  = 1'b1;
        cnt_nxt = cnt_inc;
        if ({1'b0, cx_r} + 9'd1 == {1'b0, x1_r}) begin
          cx_nxt = x0_r;
          if ({1'b0, cy_r} + 9'd1 == {1'b0, y1_r}) begin
            state_nxt = S_DONE;
          end else begin
            cy_nxt = cy_r + 8'd1;
          end
        end else begin
          cx_nxt = cx_r + 8'd1;
        end
      end
      S_GLYPH: begin
        px = gx[7:0];
        py = gy[7:0];
        if (gbits[gr_r] && on_scr(gx, gy)) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_inc;
        end
        if (gr_r == cfde_pkg::GLYPH_LAST_ROW) begin
          gr_nxt = 3'd0;
          gq_nxt = gq_r + 3'd1;
          if (gq_r == cfde_pkg::GLYPH_LAST_COL) begin
            state_nxt = S_DONE;
          end
        end else begin
          gr_nxt = gr_r + 3'd1;
        end
      end
      S_RDWAIT: begin
        rc_nxt    = rd_on_r ? mem_rdata_r : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = rc_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    mem_addr = (state_r == S_CLEAR) ? clr_r :
               AW'(32'(py) * SCREEN_WIDTH + 32'(px));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      brow_r      <= 8'd0;
      bcol_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      brow_r      <= brow_nxt;
      bcol_r      <= bcol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    color_r     <= color_nxt;
    code_r      <= code_nxt;
    first_r     <= first_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    x0_r        <= x0_nxt;
    x1_r        <= x1_nxt;
    y1_r        <= y1_nxt;
    gidx_r      <= gidx_nxt;
    gq_r        <= gq_nxt;
    gr_r        <= gr_nxt;
    rd_on_r     <= rd_on_nxt;
    cnt_r       <= cnt_nxt;
    rc_r        <= rc_nxt;
    out_color_r <= out_color_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

endmodule
